FILE: hdl/nrt_pkg.sv
// ----------------------------------------------------------------------------
// nrt_pkg
// Shared types and constants of the NIC ring tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package nrt_pkg;

  // ring and counter geometry
  localparam int TX_SLOTS        = 4;
  localparam int TX_BUFFER_BYTES = 1792;
  localparam int RX_RING_BYTES   = 32768;  // power of two
  localparam int COUNTER_BITS    = 32;

  localparam int TX_MOD   = 2 * TX_SLOTS;
  localparam int TX_CNT_W = $clog2(TX_MOD);
  localparam int NUM_CNT  = 15;
  localparam int CNT_IDX_W = 4;

  localparam logic [15:0] MIN_FRAME = 16'd60;

  // tx status bits
  localparam logic [31:0] TXS_OK        = 32'h0000_8000;
  localparam logic [31:0] TXS_UNDERRUN  = 32'h0000_4000;
  localparam logic [31:0] TXS_ABORTED   = 32'h4000_0000;
  localparam logic [31:0] TXS_WINDOW    = 32'h2000_0000;
  localparam logic [31:0] TXS_CARRIER   = 32'h8000_0000;
  localparam logic [31:0] TX_BYTE_MASK  = 32'h0000_07ff;

  // rx header status bits
  localparam logic [15:0] RXS_MULTICAST = 16'h8000;
  localparam logic [15:0] RXS_LENGTH    = 16'h0018;
  localparam logic [15:0] RXS_CRC       = 16'h0004;
  localparam logic [15:0] RXS_FRAME     = 16'h0002;
  localparam logic [15:0] RX_PTR_BIAS   = 16'd16;

  typedef enum logic [2:0] {
    KIND_TX_SUBMIT = 3'd0,
    KIND_TX_STATUS = 3'd1,
    KIND_RX_HEADER = 3'd2,
    KIND_CNT_READ  = 3'd3,
    KIND_RING_CLR  = 3'd4
  } kind_e;

  // statistics counter indices
  localparam int C_TXP    = 0;
  localparam int C_TXB    = 1;
  localparam int C_TXDROP = 2;
  localparam int C_TXERR  = 3;
  localparam int C_TXABRT = 4;
  localparam int C_TXFIFO = 5;
  localparam int C_TXWIN  = 6;
  localparam int C_TXCAR  = 7;
  localparam int C_RXP    = 8;
  localparam int C_RXB    = 9;
  localparam int C_RXERR  = 10;
  localparam int C_RXMC   = 11;
  localparam int C_RXLEN  = 12;
  localparam int C_RXCRC  = 13;
  localparam int C_RXFRM  = 14;

  typedef struct packed {
    logic [2:0]           kind;
    logic [15:0]          frame_length;
    logic [31:0]          status_word;
    logic                 buffer_unavailable;
    logic [CNT_IDX_W-1:0] counter_index;
  } item_t;

  // counter update request; bytes counters add the amounts, others add one
  typedef struct packed {
    logic [NUM_CNT-1:0] inc;
    logic [10:0]        tx_bytes;
    logic [15:0]        rx_bytes;
  } stat_upd_t;

  typedef struct packed {
    logic [1:0]  tx_slot;
    logic        tx_accepted;
    logic [31:0] tx_length_word;
    logic        ring_full;
    logic        tx_retired;
  } tx_res_t;

  typedef struct packed {
    logic [16:0] rx_header_offset;
    logic [15:0] rx_read_pointer;
    logic [15:0] rx_payload_length;
  } rx_res_t;

  typedef struct packed {
    tx_res_t     tx;
    rx_res_t     rx;
    logic [31:0] counter_value;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/nic_ring_tracker_top.sv
// ----------------------------------------------------------------------------
// nic_ring_tracker_top
// Transmit descriptor ring and receive ring bookkeeping with statistics.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the output side keeps up. An accepted
// item lands in an input register, is evaluated against the ring counts, rx
// offset and counters in a single combinational pass, and its result is
// captured in the output register once that register is free or being
// emptied; it is presented from there until the output side takes it.
// State is updated as the item moves into the
// output register, so items see the effects of all earlier items in order
// (a counter read reflects every item accepted before it). The input side
// keeps accepting while a result waits, as long as the input register can
// pass its item on; ready is combinational from out_ready_i. The tx_flags
// register is written through the cfg channel, which is always ready; write
// it only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module nic_ring_tracker_top import nrt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  // item input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [15:0] frame_length_i,
  input  wire logic [31:0] status_word_i,
  input  wire logic        buffer_unavailable_i,
  input  wire logic [3:0]  counter_index_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       tx_slot_o,
  output logic             tx_accepted_o,
  output logic [31:0]      tx_length_word_o,
  output logic             ring_full_o,
  output logic             tx_retired_o,
  output logic [16:0]      rx_header_offset_o,
  output logic [15:0]      rx_read_pointer_o,
  output logic [15:0]      rx_payload_length_o,
  output logic [31:0]      counter_value_o
);

  logic        in_vld_q, out_vld_q, fire;
  item_t       item_q;
  res_t        res_d, res_q;
  logic [31:0] tx_flags_q;
  stat_upd_t   tx_upd, rx_upd, upd;

  // the item in the input register moves on when the output slot frees up
  assign fire        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || fire;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_flags_q <= '0;
    end else if (cfg_valid_i) begin
      tx_flags_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (fire)             out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{kind: kind_i, frame_length: frame_length_i,
                  status_word: status_word_i,
                  buffer_unavailable: buffer_unavailable_i,
                  counter_index: counter_index_i};
    end
    if (fire) res_q <= res_d;
  end

  nrt_tx_ring u_tx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (item_q),
    .tx_flags_i (tx_flags_q),
    .res_o      (res_d.tx),
    .upd_o      (tx_upd)
  );

  nrt_rx_ring u_rx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .res_o  (res_d.rx),
    .upd_o  (rx_upd)
  );

  // tx and rx never raise the same counter; byte amounts come from each side
  always_comb begin
    upd          = '0;
    upd.inc      = tx_upd.inc | rx_upd.inc;
    upd.tx_bytes = tx_upd.tx_bytes;
    upd.rx_bytes = rx_upd.rx_bytes;
  end

  nrt_stats u_stats (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .upd_i     (upd),
    .rd_en_i   (item_q.kind == KIND_CNT_READ),
    .rd_idx_i  (item_q.counter_index),
    .rd_data_o (res_d.counter_value)
  );

  assign out_valid_o         = out_vld_q;
  assign tx_slot_o           = res_q.tx.tx_slot;
  assign tx_accepted_o       = res_q.tx.tx_accepted;
  assign tx_length_word_o    = res_q.tx.tx_length_word;
  assign ring_full_o         = res_q.tx.ring_full;
  assign tx_retired_o        = res_q.tx.tx_retired;
  assign rx_header_offset_o  = res_q.rx.rx_header_offset;
  assign rx_read_pointer_o   = res_q.rx.rx_read_pointer;
  assign rx_payload_length_o = res_q.rx.rx_payload_length;
  assign counter_value_o     = res_q.counter_value;

endmodule

`default_nettype wire

FILE: hdl/nrt_tx_ring.sv
// ----------------------------------------------------------------------------
// nrt_tx_ring
// Transmit descriptor ring counts: submit, completion and clear handling.
// ----------------------------------------------------------------------------
`default_nettype none

module nrt_tx_ring import nrt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire item_t       item_i,
  input  wire logic [31:0] tx_flags_i,
  output tx_res_t          res_o,
  output stat_upd_t        upd_o
);

  localparam logic [TX_CNT_W-1:0] MOD_M1 = TX_CNT_W'(TX_MOD - 1);
  localparam logic [TX_CNT_W-1:0] SLOTS  = TX_CNT_W'(TX_SLOTS);
  localparam logic [TX_CNT_W-1:0] MODV   = TX_CNT_W'(TX_MOD);

  logic [TX_CNT_W-1:0] sub_q, sub_d, ret_q, ret_d;
  logic [TX_CNT_W-1:0] pend, pend_next;
  logic [TX_CNT_W-1:0] sub_slot, ret_slot;
  logic                len_ok, done;
  logic [15:0]         len_min;
  logic [31:0]         st;

  function automatic logic [TX_CNT_W-1:0] pend_of(input logic [TX_CNT_W-1:0] s,
                                                  input logic [TX_CNT_W-1:0] r);
    if (s >= r) pend_of = s - r;
    else        pend_of = s + (MODV - r);
  endfunction

  function automatic logic [TX_CNT_W-1:0] incr(input logic [TX_CNT_W-1:0] v);
    incr = (v == MOD_M1) ? '0 : v + 1'b1;
  endfunction

  assign st       = item_i.status_word;
  assign pend     = pend_of(sub_q, ret_q);
  assign sub_slot = (sub_q >= SLOTS) ? sub_q - SLOTS : sub_q;
  assign ret_slot = (ret_q >= SLOTS) ? ret_q - SLOTS : ret_q;
  assign len_ok   = item_i.frame_length < 16'(TX_BUFFER_BYTES);
  assign len_min  = (item_i.frame_length < MIN_FRAME) ? MIN_FRAME : item_i.frame_length;
  assign done     = |(st & (TXS_OK | TXS_UNDERRUN | TXS_ABORTED));

  always_comb begin
    sub_d = sub_q;
    ret_d = ret_q;
    res_o = '0;
    upd_o = '0;
    upd_o.tx_bytes = st[10:0] & TX_BYTE_MASK[10:0];
    case (item_i.kind)
      KIND_TX_SUBMIT: begin
        res_o.tx_slot = 2'(sub_slot);
        if (pend < SLOTS && len_ok) begin
          res_o.tx_accepted    = 1'b1;
          res_o.tx_length_word = tx_flags_i | {16'd0, len_min};
          sub_d = incr(sub_q);
        end else begin
          upd_o.inc[C_TXDROP] = 1'b1;
        end
      end
      KIND_TX_STATUS: begin
        res_o.tx_slot = 2'(ret_slot);
        if (pend != '0 && done) begin
          if ((st & TXS_OK) != '0) begin
            upd_o.inc[C_TXP] = 1'b1;
            upd_o.inc[C_TXB] = 1'b1;
          end else begin
            upd_o.inc[C_TXERR]  = 1'b1;
            upd_o.inc[C_TXABRT] = (st & TXS_ABORTED) != '0;
            upd_o.inc[C_TXFIFO] = (st & TXS_UNDERRUN) != '0;
            upd_o.inc[C_TXWIN]  = (st & TXS_WINDOW) != '0;
            upd_o.inc[C_TXCAR]  = (st & TXS_CARRIER) != '0;
          end
          ret_d = incr(ret_q);
          res_o.tx_retired = 1'b1;
        end
      end
      KIND_RING_CLR: begin
        sub_d = '0;
        ret_d = '0;
      end
      default: ;
    endcase
    pend_next       = pend_of(sub_d, ret_d);
    res_o.ring_full = pend_next >= SLOTS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
      ret_q <= '0;
    end else if (fire_i) begin
      sub_q <= sub_d;
      ret_q <= ret_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/nrt_rx_ring.sv
// ----------------------------------------------------------------------------
// nrt_rx_ring
// Receive ring read offset: header position, aligned advance, counter bumps.
// ----------------------------------------------------------------------------
`default_nettype none

module nrt_rx_ring import nrt_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  fire_i,
  input  wire item_t item_i,
  output rx_res_t    res_o,
  output stat_upd_t  upd_o
);

  localparam logic [16:0] RING = 17'(RX_RING_BYTES);
  localparam logic [16:0] MASK = 17'(RX_RING_BYTES - 1);

  logic [16:0] off_q, off_d, off_eff, sum;
  logic [15:0] size, pkt, st;
  logic        is_rx;

  assign is_rx   = item_i.kind == KIND_RX_HEADER;
  assign size    = item_i.status_word[31:16];
  assign st      = item_i.status_word[15:0];
  assign pkt     = size - 16'd4;
  // past the ring end: fold back (ring size is a power of two)
  assign off_eff = (off_q > RING) ? (off_q & MASK) : off_q;
  assign sum     = off_eff + {1'b0, size} + 17'd7;
  assign off_d   = {sum[16:2], 2'b00};

  always_comb begin
    res_o = '0;
    upd_o = '0;
    upd_o.rx_bytes = pkt;
    if (is_rx) begin
      res_o.rx_header_offset  = off_eff;
      res_o.rx_read_pointer   = off_d[15:0] - RX_PTR_BIAS;
      res_o.rx_payload_length = pkt;
      if (!item_i.buffer_unavailable) begin
        upd_o.inc[C_RXP] = 1'b1;
        upd_o.inc[C_RXB] = 1'b1;
      end else begin
        upd_o.inc[C_RXERR] = 1'b1;
        upd_o.inc[C_RXMC]  = (st & RXS_MULTICAST) != '0;
        upd_o.inc[C_RXLEN] = (st & RXS_LENGTH) != '0;
        upd_o.inc[C_RXCRC] = (st & RXS_CRC) != '0;
        upd_o.inc[C_RXFRM] = (st & RXS_FRAME) != '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else if (fire_i && is_rx) begin
      off_q <= off_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/nrt_stats.sv
// ----------------------------------------------------------------------------
// nrt_stats
// Wrapping statistics counters with indexed read.
// ----------------------------------------------------------------------------
`default_nettype none

module nrt_stats import nrt_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 fire_i,
  input  wire stat_upd_t            upd_i,
  input  wire logic                 rd_en_i,
  input  wire logic [CNT_IDX_W-1:0] rd_idx_i,
  output logic [31:0]               rd_data_o
);

  logic [COUNTER_BITS-1:0] cnt_q [NUM_CNT];
  logic [COUNTER_BITS-1:0] by    [NUM_CNT];

  always_comb begin
    for (int i = 0; i < NUM_CNT; i++) by[i] = COUNTER_BITS'(1);
    by[C_TXB] = COUNTER_BITS'(upd_i.tx_bytes);
    by[C_RXB] = COUNTER_BITS'(upd_i.rx_bytes);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CNT; i++) cnt_q[i] <= '0;
    end else if (fire_i) begin
      for (int i = 0; i < NUM_CNT; i++) begin
        if (upd_i.inc[i]) cnt_q[i] <= cnt_q[i] + by[i];
      end
    end
  end

  always_comb begin
    rd_data_o = '0;
    if (rd_en_i && rd_idx_i < CNT_IDX_W'(NUM_CNT)) begin
      rd_data_o = 32'(cnt_q[rd_idx_i]);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/nrt_checker.sv
// ----------------------------------------------------------------------------
// nrt_checker
// Port-level checks on the ring tracker result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module nrt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        tx_accepted_o,
  input wire logic [31:0] tx_length_word_o,
  input wire logic        ring_full_o,
  input wire logic        tx_retired_o,
  input wire logic [15:0] rx_read_pointer_o,
  input wire logic [31:0] counter_value_o
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tx_length_word_o))
    else $error("result dropped or changed while stalled");

  // a submit result carries nothing from the completion or counter paths
  a_submit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_accepted_o |-> !tx_retired_o && counter_value_o == 32'd0)
    else $error("accepted submit mixed with other result kinds");

  // retiring a slot always leaves room in the ring
  a_retire_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_retired_o |-> !ring_full_o)
    else $error("ring full right after a retire");

  // rx offset is word aligned, so the biased pointer is too
  a_rx_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rx_read_pointer_o[1:0] == 2'b00)
    else $error("rx read pointer not word aligned");

endmodule

bind nic_ring_tracker_top nrt_checker u_nrt_checker (.*);

`default_nettype wire

FILE: tb/tb_nic_ring_tracker_top.sv
// ----------------------------------------------------------------------------
// tb_nic_ring_tracker_top
// Self-checking bench for the NIC ring tracker. A behavioural copy of the tx
// ring counts, rx offset and statistics counters predicts every result. A
// short directed run covers the corner cases, then random traffic follows
// under random gaps and backpressure, with tx_flags changed between phases.
// ----------------------------------------------------------------------------
module tb_nic_ring_tracker_top import nrt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int MAX_WAIT       = 17;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 206;   // items per phase, unused kind codes not counted
  localparam int CHUNK_ITEMS    = 40;
  localparam int UNUSED_KINDS   = 3;     // kind codes above ring clear
  localparam logic [31:0] TX_DONE_MASK = TXS_OK | TXS_UNDERRUN | TXS_ABORTED;

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  kind_i;
  logic [15:0] frame_length_i;
  logic [31:0] status_word_i;
  logic        buffer_unavailable_i;
  logic [3:0]  counter_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  tx_slot_o;
  logic        tx_accepted_o;
  logic [31:0] tx_length_word_o;
  logic        ring_full_o;
  logic        tx_retired_o;
  logic [16:0] rx_header_offset_o;
  logic [15:0] rx_read_pointer_o;
  logic [15:0] rx_payload_length_o;
  logic [31:0] counter_value_o;

  nic_ring_tracker_top u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .kind_i               (kind_i),
    .frame_length_i       (frame_length_i),
    .status_word_i        (status_word_i),
    .buffer_unavailable_i (buffer_unavailable_i),
    .counter_index_i      (counter_index_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .tx_slot_o            (tx_slot_o),
    .tx_accepted_o        (tx_accepted_o),
    .tx_length_word_o     (tx_length_word_o),
    .ring_full_o          (ring_full_o),
    .tx_retired_o         (tx_retired_o),
    .rx_header_offset_o   (rx_header_offset_o),
    .rx_read_pointer_o    (rx_read_pointer_o),
    .rx_payload_length_o  (rx_payload_length_o),
    .counter_value_o      (counter_value_o)
  );

  // --------------------------------------------------------------------------
  // Shadow state: what the block should hold after every accepted item
  // --------------------------------------------------------------------------
  logic [31:0]         flags_q;
  logic [TX_CNT_W-1:0] submitted_q;   // accepted submits, modulo 2*TX_SLOTS
  logic [TX_CNT_W-1:0] retired_q;     // retired slots, modulo 2*TX_SLOTS
  logic [16:0]         rx_offset_q;
  logic [31:0]         stats_q [NUM_CNT];

  res_t due_results[$];   // results still owed by the block, oldest first
  int   errors;
  int   idle_cycles;
  bit   no_idle;          // both sides run flat out while set

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Watchdog: any handshake counts as progress
  // --------------------------------------------------------------------------
  initial idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_nic_ring_tracker_top: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // slots in flight; TX_MOD is a power of two so plain subtraction wraps
  function automatic logic [TX_CNT_W-1:0] tx_in_flight();
    return submitted_q - retired_q;
  endfunction

  // Applies one item to the shadow state and returns the result it causes.
  function automatic res_t ring_bookkeeping(item_t it);
    res_t        r;
    logic [31:0] len_w;
    logic [31:0] next_ofs;
    logic [15:0] pkt_len;
    r = '0;
    case (it.kind)
      KIND_TX_SUBMIT: begin
        r.tx.tx_slot = 2'(submitted_q % TX_SLOTS);
        if (tx_in_flight() < TX_SLOTS && it.frame_length < TX_BUFFER_BYTES) begin
          // runts are padded up to the minimum frame
          len_w = {16'd0, (it.frame_length < MIN_FRAME) ? MIN_FRAME : it.frame_length};
          r.tx.tx_accepted    = 1'b1;
          r.tx.tx_length_word = flags_q | len_w;
          submitted_q++;
        end else begin
          stats_q[C_TXDROP]++;
        end
      end
      KIND_TX_STATUS: begin
        r.tx.tx_slot = 2'(retired_q % TX_SLOTS);
        // nothing pending, or status not done yet: no change
        if (tx_in_flight() != 0 && (it.status_word & TX_DONE_MASK) != 0) begin
          if ((it.status_word & TXS_OK) != 0) begin
            stats_q[C_TXP]++;
            stats_q[C_TXB] += it.status_word & TX_BYTE_MASK;
          end else begin
            // error bits are tested one by one, never multiplied
            stats_q[C_TXERR]++;
            if ((it.status_word & TXS_ABORTED) != 0)  stats_q[C_TXABRT]++;
            if ((it.status_word & TXS_UNDERRUN) != 0) stats_q[C_TXFIFO]++;
            if ((it.status_word & TXS_WINDOW) != 0)   stats_q[C_TXWIN]++;
            if ((it.status_word & TXS_CARRIER) != 0)  stats_q[C_TXCAR]++;
          end
          retired_q++;
          r.tx.tx_retired = 1'b1;
        end
      end
      KIND_RX_HEADER: begin
        pkt_len = it.status_word[31:16] - 16'd4;
        // past the ring end wraps; exactly at the end stays (padding area)
        if (rx_offset_q > RX_RING_BYTES) rx_offset_q = 17'(rx_offset_q % RX_RING_BYTES);
        r.rx.rx_header_offset = rx_offset_q;
        if (!it.buffer_unavailable) begin
          stats_q[C_RXP]++;
          stats_q[C_RXB] += {16'd0, pkt_len};
        end else begin
          stats_q[C_RXERR]++;
          if ((it.status_word[15:0] & RXS_MULTICAST) != 0) stats_q[C_RXMC]++;
          if ((it.status_word[15:0] & RXS_LENGTH) != 0)    stats_q[C_RXLEN]++;
          if ((it.status_word[15:0] & RXS_CRC) != 0)       stats_q[C_RXCRC]++;
          if ((it.status_word[15:0] & RXS_FRAME) != 0)     stats_q[C_RXFRM]++;
        end
        // header plus payload, rounded up to a dword, 17-bit wrap
        next_ofs = ({15'd0, rx_offset_q} + {16'd0, it.status_word[31:16]} + 32'd7)
                   & ~32'd3;
        rx_offset_q = next_ofs[16:0];
        r.rx.rx_read_pointer   = next_ofs[15:0] - RX_PTR_BIAS;
        r.rx.rx_payload_length = pkt_len;
      end
      KIND_CNT_READ: begin
        if (it.counter_index < NUM_CNT) r.counter_value = stats_q[it.counter_index];
      end
      KIND_RING_CLR: begin
        submitted_q = '0;
        retired_q   = '0;
      end
      default: ;   // unused kind codes leave everything alone
    endcase
    r.tx.ring_full = (tx_in_flight() >= TX_SLOTS);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want_v);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want_v);
    errors++;
  endtask

  task automatic check_result();
    res_t want;
    if (due_results.size() == 0) begin
      report_mismatch("result with none outstanding", 32'd0, 32'd0);
      return;
    end
    want = due_results.pop_front();
    if (tx_slot_o !== want.tx.tx_slot)
      report_mismatch("tx_slot", 32'(tx_slot_o), 32'(want.tx.tx_slot));
    if (tx_accepted_o !== want.tx.tx_accepted)
      report_mismatch("tx_accepted", 32'(tx_accepted_o), 32'(want.tx.tx_accepted));
    if (tx_length_word_o !== want.tx.tx_length_word)
      report_mismatch("tx_length_word", tx_length_word_o, want.tx.tx_length_word);
    if (ring_full_o !== want.tx.ring_full)
      report_mismatch("ring_full", 32'(ring_full_o), 32'(want.tx.ring_full));
    if (tx_retired_o !== want.tx.tx_retired)
      report_mismatch("tx_retired", 32'(tx_retired_o), 32'(want.tx.tx_retired));
    if (rx_header_offset_o !== want.rx.rx_header_offset)
      report_mismatch("rx_header_offset", 32'(rx_header_offset_o),
                      32'(want.rx.rx_header_offset));
    if (rx_read_pointer_o !== want.rx.rx_read_pointer)
      report_mismatch("rx_read_pointer", 32'(rx_read_pointer_o),
                      32'(want.rx.rx_read_pointer));
    if (rx_payload_length_o !== want.rx.rx_payload_length)
      report_mismatch("rx_payload_length", 32'(rx_payload_length_o),
                      32'(want.rx.rx_payload_length));
    if (counter_value_o !== want.counter_value)
      report_mismatch("counter_value", counter_value_o, want.counter_value);
  endtask

  // cycles a side holds off before its next item; at least a quarter of draws are zero
  function automatic int draw_wait();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Result side: stall at random, then take one item and check it.
  initial begin : result_sink
    int stall;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_result();
    end
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  // Valid stays high across back-to-back items; it is only dropped for a gap or a drain.
  task automatic send_item(item_t it);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    kind_i               <= it.kind;
    frame_length_i       <= it.frame_length;
    status_word_i        <= it.status_word;
    buffer_unavailable_i <= it.buffer_unavailable;
    counter_index_i      <= it.counter_index;
    do @(posedge clk_i); while (!in_ready_o);
    due_results.push_back(ring_bookkeeping(it));
  endtask

  // Stop sending and let every owed result come back, plus a little slack.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Only called with the block drained.
  task automatic write_flags(logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    flags_q = value;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic item_t mk_item(logic [2:0] kind, logic [15:0] len, logic [31:0] st,
                                    logic nobuf, logic [3:0] idx);
    item_t it;
    it.kind               = kind;
    it.frame_length       = len;
    it.status_word        = st;
    it.buffer_unavailable = nobuf;
    it.counter_index      = idx;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------
  // Fresh counters, a read past the last counter and an unused kind code.
  task automatic test_reset_state();
    send_item(mk_item(KIND_CNT_READ, 16'd0, 32'd0, 1'b0, 4'(C_TXP)));
    send_item(mk_item(KIND_CNT_READ, 16'hffff, 32'hffff_ffff, 1'b1, 4'(NUM_CNT)));
    send_item(mk_item(3'(KIND_RING_CLR + UNUSED_KINDS), 16'hffff, 32'hffff_ffff,
                      1'b1, 4'(C_TXDROP)));
  endtask

  // Runt padding, the length limit, and refusal once all slots are taken.
  task automatic test_tx_submit();
    send_item(mk_item(KIND_TX_SUBMIT, 16'd0, 32'd0, 1'b0, 4'd0));
    send_item(mk_item(KIND_TX_SUBMIT, MIN_FRAME - 16'd1, 32'd0, 1'b0, 4'd0));
    send_item(mk_item(KIND_TX_SUBMIT, MIN_FRAME, 32'd0, 1'b0, 4'd0));
    send_item(mk_item(KIND_TX_SUBMIT, 16'(TX_BUFFER_BYTES - 1), 32'd0, 1'b0, 4'd0));
    send_item(mk_item(KIND_TX_SUBMIT, 16'd100, 32'd0, 1'b0, 4'd0));
    send_item(mk_item(KIND_TX_SUBMIT, 16'(TX_BUFFER_BYTES), 32'd0, 1'b0, 4'd0));
  endtask

  // Not-done status, success, each error flavour, then an empty ring.
  task automatic test_tx_completion();
    send_item(mk_item(KIND_TX_STATUS, 16'd0, ~TX_DONE_MASK, 1'b0, 4'd0));
    send_item(mk_item(KIND_TX_STATUS, 16'd0, TXS_OK | TX_BYTE_MASK, 1'b0, 4'd0));
    send_item(mk_item(KIND_TX_STATUS, 16'd0, TXS_UNDERRUN | TXS_WINDOW, 1'b0, 4'd0));
    send_item(mk_item(KIND_TX_STATUS, 16'd0, TXS_ABORTED | TXS_CARRIER, 1'b0, 4'd0));
    send_item(mk_item(KIND_TX_STATUS, 16'd0, TXS_OK | 32'd64, 1'b0, 4'd0));
    send_item(mk_item(KIND_TX_STATUS, 16'd0, TXS_OK, 1'b0, 4'd0));
    // room in the ring but the frame is too long
    send_item(mk_item(KIND_TX_SUBMIT, 16'hffff, 32'd0, 1'b0, 4'd0));
  endtask

  // Pointer below the bias, landing exactly on the ring end, then past it.
  task automatic test_rx_header();
    send_item(mk_item(KIND_RX_HEADER, 16'd0, 32'h0000_0000, 1'b0, 4'd0));
    send_item(mk_item(KIND_RX_HEADER, 16'd0,
                      {16'(RX_RING_BYTES - 8), 16'h0001}, 1'b0, 4'd0));
    send_item(mk_item(KIND_RX_HEADER, 16'd0, {16'd8, 16'h0001}, 1'b0, 4'd0));
    send_item(mk_item(KIND_RX_HEADER, 16'd0,
                      {16'hffff, RXS_MULTICAST | RXS_LENGTH | RXS_CRC | RXS_FRAME},
                      1'b1, 4'd0));
  endtask

  // Clear drops the ring counts but keeps the statistics.
  task automatic test_ring_clear();
    send_item(mk_item(KIND_TX_SUBMIT, 16'd200, 32'd0, 1'b0, 4'd0));
    send_item(mk_item(KIND_RING_CLR, 16'd0, 32'd0, 1'b0, 4'd0));
    send_item(mk_item(KIND_CNT_READ, 16'd0, 32'd0, 1'b0, 4'(C_TXDROP)));
    send_item(mk_item(KIND_CNT_READ, 16'd0, 32'd0, 1'b0, 4'(C_RXB)));
    send_item(mk_item(KIND_CNT_READ, 16'd0, 32'd0, 1'b0, 4'(C_TXB)));
  endtask

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------
  // Mostly well-formed submit/complete/receive traffic; every field is
  // randomised in full underneath so unused bits still toggle.
  function automatic item_t random_item();
    item_t       it;
    int          pick;
    logic [15:0] rx_size;
    it.frame_length       = 16'($urandom);
    it.status_word        = $urandom;
    it.buffer_unavailable = ($urandom_range(0, 3) == 0);
    it.counter_index      = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.kind = KIND_TX_SUBMIT;
      case ($urandom_range(0, 9))
        0:       ;   // full 16-bit length, mostly refused
        1:       it.frame_length = 16'($urandom_range(0, 64));
        2:       it.frame_length = 16'($urandom_range(TX_BUFFER_BYTES - 2,
                                                      TX_BUFFER_BYTES + 1));
        default: it.frame_length = 16'($urandom_range(0, TX_BUFFER_BYTES - 1));
      endcase
    end else if (pick < 60) begin
      it.kind = KIND_TX_STATUS;
      case ($urandom_range(0, 9))
        0, 1:    ;   // raw status, may or may not show done
        2:       it.status_word &= ~TX_DONE_MASK;
        3, 4:    it.status_word = (it.status_word & ~TX_DONE_MASK) | TXS_UNDERRUN;
        5:       it.status_word = (it.status_word & ~TX_DONE_MASK) | TXS_ABORTED;
        default: it.status_word |= TXS_OK;
      endcase
    end else if (pick < 80) begin
      it.kind = KIND_RX_HEADER;
      case ($urandom_range(0, 4))
        0:       rx_size = 16'($urandom);
        1:       rx_size = 16'($urandom_range(0, 16));
        default: rx_size = 16'($urandom_range(0, 1600));
      endcase
      it.status_word[31:16] = rx_size;
    end else if (pick < 94) begin
      it.kind = KIND_CNT_READ;
    end else if (pick < 97) begin
      it.kind = KIND_RING_CLR;
    end else begin
      it.kind = 3'(KIND_RING_CLR + $urandom_range(1, UNUSED_KINDS));
    end
    return it;
  endfunction

  // Phases with different tx_flags, including both extremes; idle-free
  // bursts and mid-phase drains are mixed in.
  task automatic test_random_traffic();
    item_t it;
    int    sent;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0:       write_flags(32'h0000_0000);
        1:       write_flags(32'hffff_ffff);
        2:       write_flags($urandom & 32'hffff_f800);   // leaves the length bits clear
        default: write_flags($urandom);
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (sent % CHUNK_ITEMS == 0) begin
          no_idle = ($urandom_range(0, 3) == 0);
          // hold the sender until every owed result is back
          if ($urandom_range(0, 2) == 0) drain();
        end
        it = random_item();
        send_item(it);
        if (it.kind <= KIND_RING_CLR) sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni               <= 1'b0;
    cfg_valid_i          <= 1'b0;
    cfg_data_i           <= '0;
    in_valid_i           <= 1'b0;
    kind_i               <= '0;
    frame_length_i       <= '0;
    status_word_i        <= '0;
    buffer_unavailable_i <= 1'b0;
    counter_index_i      <= '0;
    errors      = 0;
    no_idle     = 1'b0;
    flags_q     = '0;
    submitted_q = '0;
    retired_q   = '0;
    rx_offset_q = '0;
    for (int i = 0; i < NUM_CNT; i++) stats_q[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    drain();
    write_flags(32'h8020_0000);
    test_tx_submit();
    test_tx_completion();
    test_rx_header();
    test_ring_clear();
    test_random_traffic();
    drain();

    if (errors == 0 && due_results.size() == 0) begin
      $display("tb_nic_ring_tracker_top: done, clean");
    end else begin
      $display("tb_nic_ring_tracker_top: done, errors");
    end
    $finish;
  end

endmodule
